/* rtl/core/bbd_pkg.sv */
// Shared constants for the bilinear Bayer demosaic block.
`default_nettype none
package bbd_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_WIDTH   = 2'd0;
    localparam logic [1:0] REG_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_PATTERN = 2'd2;

    // Color filter orders
    localparam logic [1:0] PAT_RGGB = 2'd0;
    localparam logic [1:0] PAT_BGGR = 2'd1;
    localparam logic [1:0] PAT_GRBG = 2'd2;
    localparam logic [1:0] PAT_GBRG = 2'd3;

    localparam int CFG_BITS = 13;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 13'd1920;
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 13'd1080;

    typedef logic [1:0]          cfg_index_t;
    typedef logic [CFG_BITS-1:0] cfg_data_t;

endpackage
`default_nettype wire

/* rtl/core/bilinear_bayer_demosaic_top.sv */
// Top level of the streaming bilinear Bayer demosaic.
`default_nettype none
// Raw Bayer samples enter in raster order, one per cycle unless stalled; the
// block tracks the frame position itself. Two line stores (block memories,
// one read and one write per cycle) supply the two rows above the incoming
// sample, and a 3x3 window is formed from them and the last two columns. Once
// the window is centered on an interior pixel (row and column at least 2 of
// the incoming sample), that pixel's RGB is produced: missing chroma is the
// truncated mean of 2 or 4 neighbors, missing green the truncated mean of the
// 4 direct neighbors. Border pixels repeat the nearest interior result and are
// emitted alongside it, rows ascending then columns, with last_of_run on the
// final one, so one item yields 0, 1, 2 or 4 results. A sample is registered
// in stage 1 and its result in the result register. An item that yields several
// results holds the single result register until its last copy is taken, and
// the input side stalls behind it. The line stores need no clearing pass: a
// high-water mark of written columns makes never-written entries read as zero.
// The frame size used is saturated to 4..MAX_WIDTH and 4..MAX_HEIGHT.
module bilinear_bayer_demosaic_top #(
    parameter int MAX_WIDTH   = 4096,
    parameter int MAX_HEIGHT  = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire bbd_pkg::cfg_index_t  cfg_index,
    input  wire bbd_pkg::cfg_data_t   cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [15:0]          raw_sample,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [15:0]               red_value,
    output logic [15:0]               green_value,
    output logic [15:0]               blue_value,
    output logic [11:0]               pixel_row,
    output logic [11:0]               pixel_col,
    output logic                      last_of_run
);
    import bbd_pkg::*;

    localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int SB = SAMPLE_BITS;
    localparam logic [14:0] MAXW15 = 15'(MAX_WIDTH);
    localparam logic [14:0] MAXH15 = 15'(MAX_HEIGHT);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    cfg_data_t  width_reg;
    cfg_data_t  height_reg;
    logic [1:0] pattern_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            pattern_reg <= PAT_RGGB;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WIDTH:   width_reg   <= cfg_data;
                REG_HEIGHT:  height_reg  <= cfg_data;
                REG_PATTERN: pattern_reg <= cfg_data[1:0];
                default:     ;
            endcase
        end
    end

    // Saturate the frame size to the supported range.
    logic [14:0] w15;
    logic [14:0] h15;
    logic [WW-1:0] frame_w;
    logic [HW-1:0] frame_h;

    always_comb
    begin
        w15 = {2'b00, width_reg};
        h15 = {2'b00, height_reg};
        if (w15 < 15'd4)
            w15 = 15'd4;
        else if (w15 > MAXW15)
            w15 = MAXW15;
        if (h15 < 15'd4)
            h15 = 15'd4;
        else if (h15 > MAXH15)
            h15 = MAXH15;
        frame_w = WW'(w15);
        frame_h = HW'(h15);
    end

    // ------------------------------------------------------------------
    // Stage 1: accept the sample, track position, read the line stores
    // ------------------------------------------------------------------
    logic          s1_valid_reg;
    logic [SB-1:0] s1_sample_reg;
    logic [RW-1:0] s1_row_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_filled_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_next;
    logic [CW-1:0] col_next;
    logic [CW:0]   fill_reg;
    logic          in_acc;
    logic          s1_adv;
    logic          burst_free;
    logic [WW-1:0] col_inc;
    logic [HW-1:0] row_inc;

    assign in_acc   = in_valid && in_ready;
    assign s1_adv   = s1_valid_reg && burst_free;
    assign in_ready = !s1_valid_reg || s1_adv;

    // Advance the frame position, wrapping at the end of line and frame.
    always_comb
    begin
        col_inc = WW'(col_reg) + WW'(1);
        row_inc = HW'(row_reg) + HW'(1);
        row_next = row_reg;
        col_next = CW'(col_inc);
        if (col_inc >= frame_w)
        begin
            col_next = '0;
            row_next = (row_inc >= frame_h) ? '0 : RW'(row_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (in_acc)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_sample_reg <= raw_sample[SB-1:0];
            s1_row_reg    <= row_reg;
            s1_col_reg    <= col_reg;
            // A column at or past the high-water mark was never written.
            s1_filled_reg <= ({1'b0, col_reg} < fill_reg);
        end
    end

    // Line stores: read at accept, write when the item moves on.
    logic [SB-1:0] upper_mem [MAX_WIDTH];
    logic [SB-1:0] lower_mem [MAX_WIDTH];
    logic [SB-1:0] top_q;
    logic [SB-1:0] mid_q;
    logic [SB-1:0] top_px;
    logic [SB-1:0] mid_px;

    assign top_px = s1_filled_reg ? top_q : '0;
    assign mid_px = s1_filled_reg ? mid_q : '0;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            upper_mem[s1_col_reg] <= mid_px;
            lower_mem[s1_col_reg] <= s1_sample_reg;
        end
        if (in_acc)
        begin
            top_q <= upper_mem[col_reg];
            mid_q <= lower_mem[col_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (s1_adv && ({1'b0, s1_col_reg} >= fill_reg))
            fill_reg <= {1'b0, s1_col_reg} + (CW+1)'(1);
    end

    // ------------------------------------------------------------------
    // Window: the two previous columns; the new column comes from stage 1.
    // ------------------------------------------------------------------
    logic [SB-1:0] w0_reg [3];
    logic [SB-1:0] w1_reg [3];
    logic [SB-1:0] w2 [3];

    assign w2[0] = top_px;
    assign w2[1] = mid_px;
    assign w2[2] = s1_sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int y = 0; y < 3; y++)
            begin
                w0_reg[y] <= '0;
                w1_reg[y] <= '0;
            end
        end
        else if (s1_adv)
        begin
            for (int y = 0; y < 3; y++)
            begin
                w0_reg[y] <= w1_reg[y];
                w1_reg[y] <= w2[y];
            end
        end
    end

    // ------------------------------------------------------------------
    // Interpolation of the window center
    // ------------------------------------------------------------------
    logic [SB+1:0] cross_sum;
    logic [SB+1:0] diag_sum;
    logic [SB:0]   horz_sum;
    logic [SB:0]   vert_sum;
    logic [SB-1:0] ctr;
    logic [SB-1:0] cross_avg;
    logic [SB-1:0] diag_avg;
    logic [SB-1:0] horz_avg;
    logic [SB-1:0] vert_avg;
    logic [SB-1:0] red_calc;
    logic [SB-1:0] green_calc;
    logic [SB-1:0] blue_calc;
    logic          ry;
    logic          rx;
    logic          py;
    logic          px;
    logic          has_result;
    logic [RW-1:0] cr;
    logic [CW-1:0] cc;
    logic [RW-1:0] row_a_calc;
    logic [RW-1:0] row_b_calc;
    logic [CW-1:0] col_a_calc;
    logic [CW-1:0] col_b_calc;
    logic          two_rows_calc;
    logic          two_cols_calc;

    always_comb
    begin
        ctr       = w1_reg[1];
        cross_sum = (SB+2)'(w1_reg[0]) + (SB+2)'(w1_reg[2])
                  + (SB+2)'(w0_reg[1]) + (SB+2)'(w2[1]);
        diag_sum  = (SB+2)'(w0_reg[0]) + (SB+2)'(w2[0])
                  + (SB+2)'(w0_reg[2]) + (SB+2)'(w2[2]);
        horz_sum  = (SB+1)'(w0_reg[1]) + (SB+1)'(w2[1]);
        vert_sum  = (SB+1)'(w1_reg[0]) + (SB+1)'(w1_reg[2]);
        cross_avg = cross_sum[SB+1:2];
        diag_avg  = diag_sum[SB+1:2];
        horz_avg  = horz_sum[SB:1];
        vert_avg  = vert_sum[SB:1];

        cr = s1_row_reg - RW'(1);
        cc = s1_col_reg - CW'(1);
        ry = (pattern_reg == PAT_BGGR) || (pattern_reg == PAT_GBRG);
        rx = (pattern_reg == PAT_BGGR) || (pattern_reg == PAT_GRBG);
        py = cr[0];
        px = cc[0];

        if (py == ry && px == rx)
        begin
            red_calc = ctr; green_calc = cross_avg; blue_calc = diag_avg;
        end
        else if (py != ry && px != rx)
        begin
            blue_calc = ctr; green_calc = cross_avg; red_calc = diag_avg;
        end
        else if (py == ry)
        begin
            green_calc = ctr; red_calc = horz_avg; blue_calc = vert_avg;
        end
        else
        begin
            green_calc = ctr; red_calc = vert_avg; blue_calc = horz_avg;
        end

        has_result = (s1_row_reg >= RW'(2)) && (s1_col_reg >= CW'(2))
                  && (HW'(s1_row_reg) < frame_h) && (WW'(s1_col_reg) < frame_w);

        // Border rows and columns repeat the nearest interior pixel.
        two_rows_calc = (cr == RW'(1)) || (HW'(cr) == frame_h - HW'(2));
        row_a_calc    = (cr == RW'(1)) ? '0 : cr;
        row_b_calc    = (cr == RW'(1)) ? cr : RW'(frame_h - HW'(1));
        two_cols_calc = (cc == CW'(1)) || (WW'(cc) == frame_w - WW'(2));
        col_a_calc    = (cc == CW'(1)) ? '0 : cc;
        col_b_calc    = (cc == CW'(1)) ? cc : CW'(frame_w - WW'(1));
    end

    // ------------------------------------------------------------------
    // Result register: hold one pixel and step through its 1, 2 or 4 copies
    // ------------------------------------------------------------------
    logic          burst_valid_reg;
    logic [SB-1:0] red_reg;
    logic [SB-1:0] green_reg;
    logic [SB-1:0] blue_reg;
    logic [RW-1:0] row_a_reg;
    logic [RW-1:0] row_b_reg;
    logic [CW-1:0] col_a_reg;
    logic [CW-1:0] col_b_reg;
    logic          two_rows_reg;
    logic          two_cols_reg;
    logic          row_sel_reg;
    logic          col_sel_reg;
    logic          out_last;
    logic          out_acc;

    assign out_last   = (row_sel_reg == two_rows_reg) && (col_sel_reg == two_cols_reg);
    assign out_acc    = out_valid && out_ready;
    assign burst_free = !burst_valid_reg || (out_ready && out_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_valid_reg <= 1'b0;
            row_sel_reg     <= 1'b0;
            col_sel_reg     <= 1'b0;
        end
        else if (s1_adv)
        begin
            // Load the next pixel, or drop to empty if it yields nothing.
            burst_valid_reg <= has_result;
            row_sel_reg     <= 1'b0;
            col_sel_reg     <= 1'b0;
        end
        else if (out_acc)
        begin
            if (out_last)
                burst_valid_reg <= 1'b0;
            else if (col_sel_reg != two_cols_reg)
                col_sel_reg <= 1'b1;
            else
            begin
                col_sel_reg <= 1'b0;
                row_sel_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            red_reg      <= red_calc;
            green_reg    <= green_calc;
            blue_reg     <= blue_calc;
            row_a_reg    <= row_a_calc;
            row_b_reg    <= row_b_calc;
            col_a_reg    <= col_a_calc;
            col_b_reg    <= col_b_calc;
            two_rows_reg <= two_rows_calc;
            two_cols_reg <= two_cols_calc;
        end
    end

    assign out_valid   = burst_valid_reg;
    assign red_value   = 16'(red_reg);
    assign green_value = 16'(green_reg);
    assign blue_value  = 16'(blue_reg);
    assign pixel_row   = 12'(row_sel_reg ? row_b_reg : row_a_reg);
    assign pixel_col   = 12'(col_sel_reg ? col_b_reg : col_a_reg);
    assign last_of_run = out_last;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= (CW+1)'(MAX_WIDTH))
        else $error("line store high-water mark past line length");

    a_row_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (burst_valid_reg && row_sel_reg) |-> two_rows_reg)
        else $error("second row selected on a single-row pixel");

    a_col_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (burst_valid_reg && col_sel_reg) |-> two_cols_reg)
        else $error("second column selected on a single-column pixel");

    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && out_last && !s1_adv) |=> !out_valid)
        else $error("result register not empty after last copy");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_col_reg)))
        else $error("stage 1 item lost while stalled");
`endif

endmodule
`default_nettype wire

/* bench/bilinear_bayer_demosaic_top_test.sv */
// Self-checking testbench for the streaming bilinear Bayer demosaic block.
`default_nettype none

// One predicted output pixel
typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [11:0] row;
    logic [11:0] col;
    logic        last;
} rgb_pixel_t;

// Predicts demosaiced pixels from accepted raw samples and checks the output stream.
class demosaic_scoreboard;
    logic [15:0] upper_line[4096];
    logic [15:0] lower_line[4096];
    logic [15:0] win[9];
    int unsigned row_pos;
    int unsigned col_pos;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [1:0]  pattern_reg;
    rgb_pixel_t  pixels_due[$];
    int          mismatches;

    function new();
        foreach (upper_line[i]) upper_line[i] = '0;
        foreach (lower_line[i]) lower_line[i] = '0;
        foreach (win[i]) win[i] = '0;
        row_pos = 0;
        col_pos = 0;
        width_reg = bbd_pkg::WIDTH_RESET;
        height_reg = bbd_pkg::HEIGHT_RESET;
        pattern_reg = bbd_pkg::PAT_RGGB;
        mismatches = 0;
    endfunction

    function void write_reg(bbd_pkg::cfg_index_t idx, bbd_pkg::cfg_data_t val);
        case (idx)
            bbd_pkg::REG_WIDTH:   width_reg = val;
            bbd_pkg::REG_HEIGHT:  height_reg = val;
            bbd_pkg::REG_PATTERN: pattern_reg = val[1:0];
            default: ;
        endcase
    endfunction

    function int unsigned sat_size(int unsigned v);
        if (v < 4) return 4;
        if (v > 4096) return 4096;
        return v;
    endfunction

    // Advance the window and line stores by one sample; queue the pixels it completes.
    function void note_sample(logic [15:0] s);
        int unsigned w, h, r, c, ci, cr, cc, ry, rx, py, px;
        int unsigned ctr, cross_mean, diag, horz, vert, red, green, blue;
        int unsigned rows[$], cols[$];
        rgb_pixel_t  p;
        logic [15:0] top, mid;
        w = sat_size(width_reg);
        h = sat_size(height_reg);
        r = row_pos;
        c = col_pos;
        ci = (c < 4096) ? c : 0;
        top = upper_line[ci];
        mid = lower_line[ci];
        upper_line[ci] = mid;
        lower_line[ci] = s;
        for (int y = 0; y < 3; y++) begin
            win[y*3] = win[y*3+1];
            win[y*3+1] = win[y*3+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = s;

        if (r >= 2 && c >= 2 && r < h && c < w) begin
            cr = r - 1;
            cc = c - 1;
            ry = (pattern_reg == bbd_pkg::PAT_BGGR || pattern_reg == bbd_pkg::PAT_GBRG);
            rx = (pattern_reg == bbd_pkg::PAT_BGGR || pattern_reg == bbd_pkg::PAT_GRBG);
            py = cr & 1;
            px = cc & 1;
            ctr = win[4];
            cross_mean = (win[1] + win[7] + win[3] + win[5]) >> 2;
            diag = (win[0] + win[2] + win[6] + win[8]) >> 2;
            horz = (win[3] + win[5]) >> 1;
            vert = (win[1] + win[7]) >> 1;
            if (py == ry && px == rx) begin
                red = ctr; green = cross_mean; blue = diag;
            end else if (py != ry && px != rx) begin
                blue = ctr; green = cross_mean; red = diag;
            end else if (py == ry) begin
                green = ctr; red = horz; blue = vert;
            end else begin
                green = ctr; red = vert; blue = horz;
            end
            // border rows and columns repeat the nearest interior pixel
            if (cr == 1) rows.push_back(0);
            rows.push_back(cr);
            if (cr == h - 2) rows.push_back(h - 1);
            if (cc == 1) cols.push_back(0);
            cols.push_back(cc);
            if (cc == w - 2) cols.push_back(w - 1);
            foreach (rows[i]) begin
                foreach (cols[j]) begin
                    p.red = 16'(red);
                    p.green = 16'(green);
                    p.blue = 16'(blue);
                    p.row = 12'(rows[i]);
                    p.col = 12'(cols[j]);
                    p.last = (i == rows.size() - 1) && (j == cols.size() - 1);
                    pixels_due.push_back(p);
                end
            end
        end

        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    function void check_pixel(rgb_pixel_t got);
        rgb_pixel_t want;
        if (pixels_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected pixel row %0d col %0d", got.row, got.col);
            return;
        end
        want = pixels_due.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue
            || got.row !== want.row || got.col !== want.col || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("pixel mismatch: exp r%h g%h b%h (%0d,%0d) l%b %s",
                         want.red, want.green, want.blue, want.row, want.col, want.last,
                         $sformatf("got r%h g%h b%h (%0d,%0d) l%b",
                                   got.red, got.green, got.blue, got.row, got.col,
                                   got.last));
        end
    endfunction
endclass

module bilinear_bayer_demosaic_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    bbd_pkg::cfg_index_t cfg_index = bbd_pkg::REG_WIDTH;
    bbd_pkg::cfg_data_t  cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [15:0]         raw_sample = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [15:0]         red_value, green_value, blue_value;
    logic [11:0]         pixel_row, pixel_col;
    logic                last_of_run;

    demosaic_scoreboard sb = new();

    bit run_gaps = 1'b1;        // sender and receiver idle between items when set
    bit hold_output = 1'b0;     // request one long receiver hold-off
    int idle_cycles = 0;
    int samples_sent = 0;

    bilinear_bayer_demosaic_top uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .raw_sample(raw_sample),
        .out_valid(out_valid), .out_ready(out_ready),
        .red_value(red_value), .green_value(green_value), .blue_value(blue_value),
        .pixel_row(pixel_row), .pixel_col(pixel_col), .last_of_run(last_of_run)
    );

    always #5 clk = ~clk;

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Check every pixel accepted on the output side.
    always @(posedge clk) begin
        rgb_pixel_t got;
        if (rst_n && out_valid && out_ready) begin
            got.red = red_value;
            got.green = green_value;
            got.blue = blue_value;
            got.row = pixel_row;
            got.col = pixel_col;
            got.last = last_of_run;
            sb.check_pixel(got);
        end
    end

    // Receiver: random stalls, plus one long hold-off on request so the block backs up.
    initial begin
        int gap;
        @(posedge rst_n);
        forever begin
            if (hold_output) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_output = 1'b0;
            end
            gap = run_gaps ? pick_gap() : 0;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Watchdog: count cycles in which no channel moves anything.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one sample, hold it until accepted, then note it for prediction.
    task automatic send_sample(logic [15:0] s);
        int gap;
        gap = run_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_sample <= s;
        do @(posedge clk); while (!in_ready);
        sb.note_sample(s);
        samples_sent++;
    endtask

    // Drain all pending pixels and let in-flight samples settle before touching registers.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pixels_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(bbd_pkg::cfg_index_t idx, bbd_pkg::cfg_data_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(bbd_pkg::cfg_data_t w, bbd_pkg::cfg_data_t h, logic [1:0] pat);
        wait_idle();
        write_reg(bbd_pkg::REG_WIDTH, w);
        write_reg(bbd_pkg::REG_HEIGHT, h);
        write_reg(bbd_pkg::REG_PATTERN, {11'd0, pat});
    endtask

    initial begin
        logic [1:0] pats[4];
        int n;
        pats[0] = bbd_pkg::PAT_RGGB;
        pats[1] = bbd_pkg::PAT_BGGR;
        pats[2] = bbd_pkg::PAT_GRBG;
        pats[3] = bbd_pkg::PAT_GBRG;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a 4x4 frame of extreme samples, every interior pixel next to a border.
        set_frame(13'd4, 13'd4, bbd_pkg::PAT_RGGB);
        for (int i = 0; i < 16; i++)
            send_sample(((i + i / 4) & 1) ? 16'hFFFF : 16'h0000);
        // Below-range sizes saturate to 4.
        set_frame(13'd0, 13'd1, bbd_pkg::PAT_GBRG);
        for (int i = 0; i < 8; i++) send_sample(16'(16'hFFFF - i));

        // Above-range width saturates; the next phase shrinks the frame mid-line.
        set_frame(13'h1FFF, 13'd4, bbd_pkg::PAT_BGGR);
        for (int i = 0; i < 12; i++) send_sample(16'($urandom));

        // Random phases: small frames, all orders, odd sizes, mid-frame changes.
        for (int ph = 0; samples_sent < 150; ph++) begin
            set_frame(13'($urandom_range(11, 3)), 13'($urandom_range(8, 3)), pats[ph % 4]);
            if (ph == 1) hold_output = 1'b1;
            run_gaps = ($urandom_range(3) != 0);
            n = $urandom_range(40, 15);
            for (int i = 0; i < n; i++) send_sample(16'($urandom));
        end
        run_gaps = 1'b1;

        wait_idle();
        if (sb.mismatches == 0 && sb.pixels_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
